### rtl/core/point_in_polygon_test_macros.svh
// Assertion macros used by the point-in-polygon test RTL.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ppt_pkg.sv
// Shared types and constants of the point-in-polygon test block.
package ppt_pkg;

  localparam int FIELD_W  = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int MIN_POLY = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_FEW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic vld;
    logic first;
  } edge_ctl_t;

endpackage

### rtl/core/ppt_if.sv
// Valid/ready channel interfaces for commands and results.
interface ppt_in_if;
  logic                                valid;
  logic                                ready;
  logic        [ppt_pkg::CMD_W-1:0]    command;
  logic signed [ppt_pkg::FIELD_W-1:0]  coord_x;
  logic signed [ppt_pkg::FIELD_W-1:0]  coord_y;

  modport source (output valid, command, coord_x, coord_y, input ready);
  modport sink (input valid, command, coord_x, coord_y, output ready);
endinterface

interface ppt_out_if;
  logic                               valid;
  logic                               ready;
  logic                               inside_res;
  logic [ppt_pkg::STATUS_W-1:0]       status;

  modport source (output valid, inside_res, status, input ready);
  modport sink (input valid, inside_res, status, output ready);
endinterface

### rtl/core/ppt_vstore.sv
// Vertex memory with one write port and one registered read port.
module ppt_vstore #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ppt_edge_unit.sv
// Pipelined edge evaluator that accumulates the crossing parity of one query.
module ppt_edge_unit #(
  parameter int CW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [CW-1:0]     px,
  input  logic signed [CW-1:0]     py,
  input  ppt_pkg::edge_ctl_t       ctl,
  input  logic signed [CW-1:0]     bx,
  input  logic signed [CW-1:0]     by,
  output logic                     busy,
  output logic                     in_poly
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [CW-1:0] px_r, py_r, ax_r, ay_r;
  logic signed [CW-1:0] lo, hi, xmax;

  logic                 r1_vld_r, r1_vld_nxt;
  logic                 r1_cand_r, r1_cand_nxt;
  logic                 r1_vert_r, r1_neg_r;
  logic signed [DW-1:0] dpx_r, dy_r, dpy_r, dbx_r;
  logic signed [DW-1:0] dpx_nxt, dy_nxt, dpy_nxt, dbx_nxt;

  logic                 r2_vld_r, r2_cand_r, r2_vert_r, r2_neg_r;
  logic signed [PW-1:0] lhs_r, rhs_r, lhs_nxt, rhs_nxt;

  logic                 hit;
  logic                 par_r;

  always_comb begin
    lo          = (ay_r < by) ? ay_r : by;
    hi          = (ay_r < by) ? by : ay_r;
    xmax        = (ax_r > bx) ? ax_r : bx;
    r1_vld_nxt  = ctl.vld && !ctl.first;
    r1_cand_nxt = (ay_r != by) && (py_r > lo) && (py_r <= hi) && (px_r <= xmax);
    dy_nxt      = DW'(by) - DW'(ay_r);
    dpx_nxt     = DW'(px_r) - DW'(ax_r);
    dpy_nxt     = DW'(py_r) - DW'(ay_r);
    dbx_nxt     = DW'(bx) - DW'(ax_r);
    lhs_nxt     = PW'(dpx_r) * PW'(dy_r);
    rhs_nxt     = PW'(dpy_r) * PW'(dbx_r);
    hit         = r2_cand_r && (r2_vert_r || (r2_neg_r ? (lhs_r >= rhs_r)
                                                       : (lhs_r <= rhs_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
      par_r    <= 1'b0;
    end else begin
      r1_vld_r <= r1_vld_nxt;
      r2_vld_r <= r1_vld_r;
      if (start) begin
        par_r <= 1'b0;
      end else if (r2_vld_r && hit) begin
        par_r <= ~par_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px_r <= px;
      py_r <= py;
    end
    if (ctl.vld) begin
      ax_r <= bx;
      ay_r <= by;
    end
    r1_cand_r <= r1_cand_nxt;
    r1_vert_r <= (ax_r == bx);
    r1_neg_r  <= (ay_r > by);
    dpx_r     <= dpx_nxt;
    dy_r      <= dy_nxt;
    dpy_r     <= dpy_nxt;
    dbx_r     <= dbx_nxt;
    r2_cand_r <= r1_cand_r;
    r2_vert_r <= r1_vert_r;
    r2_neg_r  <= r1_neg_r;
    lhs_r     <= lhs_nxt;
    rhs_r     <= rhs_nxt;
  end

  assign busy    = ctl.vld || r1_vld_r || r2_vld_r;
  assign in_poly = par_r;

endmodule

### rtl/core/point_in_polygon_test.sv
// Point-in-polygon test by crossing number over a stored polygon of integer vertices.
// Each transaction clears the polygon, appends a vertex, queries a point or, with the
// unused command code, changes nothing, and yields exactly one result. Clear, append,
// the unused code and a query on fewer than three vertices load the result register
// in the cycle the transaction is accepted. A query on n stored vertices reads the
// vertex memory n + 1 times (last vertex first, then all in order); the read data
// passes through the edge pipeline, and once the pipeline has settled and the
// output register is free, the result register loads. The single read port of the
// vertex memory sets the one-edge-per-cycle pace. No new transaction is taken
// while a query is in progress or while a result waits in the output register,
// except in the cycle in which that result is taken.
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input logic      clk,
  input logic      rst_n,
  ppt_in_if.sink   in_ch,
  ppt_out_if.source out_ch
);

  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int CW   = COORD_BITS;
  localparam int XW   = (CW > ppt_pkg::FIELD_W) ? CW : ppt_pkg::FIELD_W;
  localparam logic [CNTW-1:0] MIN_CNT = CNTW'(ppt_pkg::MIN_POLY);

  ppt_pkg::state_e    state_r, state_nxt;
  ppt_pkg::cmd_e      cmd;
  ppt_pkg::edge_ctl_t tag_r, tag_nxt;

  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [CNTW-1:0]     k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_inside_r, out_inside_nxt;
  logic [ppt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [XW-1:0]        x_ext, y_ext;
  logic signed [CW-1:0] px_c, py_c, bx, by;
  logic [2*CW-1:0]      rdata;

  logic acc, out_free, query_go, imm, finish, full, we;
  logic rd_en, edge_busy, edge_inside, in_ready;
  logic [IW-1:0] rd_addr;

  assign x_ext = XW'($unsigned(in_ch.coord_x));
  assign y_ext = XW'($unsigned(in_ch.coord_y));
  assign px_c  = x_ext[CW-1:0];
  assign py_c  = y_ext[CW-1:0];
  assign cmd   = ppt_pkg::cmd_e'(in_ch.command);

  assign acc      = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = (cnt_r >= CNTW'(MAX_VERTICES));
  assign query_go = acc && (cmd == ppt_pkg::CMD_QUERY) && (cnt_r >= MIN_CNT);
  assign imm      = acc && !query_go;
  assign we       = acc && (cmd == ppt_pkg::CMD_APPEND) && !full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppt_pkg::S_IDLE: begin
        if (query_go) begin
          state_nxt = ppt_pkg::S_WALK;
        end
      end
      ppt_pkg::S_WALK: begin
        if (k_r == cnt_r) begin
          state_nxt = ppt_pkg::S_DRAIN;
        end
      end
      ppt_pkg::S_DRAIN: begin
        if (!edge_busy && out_free) begin
          state_nxt = ppt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ppt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      ppt_pkg::S_IDLE:  in_ready = out_free;
      ppt_pkg::S_WALK:  rd_en = 1'b1;
      ppt_pkg::S_DRAIN: finish = !edge_busy && out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    rd_addr     = (k_r == '0) ? IW'(cnt_r - CNTW'(1)) : IW'(k_r - CNTW'(1));
    tag_nxt.vld   = rd_en;
    tag_nxt.first = (k_r == '0);
    k_nxt         = (state_r == ppt_pkg::S_WALK) ? k_r + CNTW'(1) : '0;

    cnt_nxt = cnt_r;
    if (acc && (cmd == ppt_pkg::CMD_CLEAR)) begin
      cnt_nxt = '0;
    end else if (we) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end

    out_inside_nxt = out_inside_r;
    out_status_nxt = out_status_r;
    if (imm) begin
      out_inside_nxt = 1'b0;
      unique case (cmd)
        ppt_pkg::CMD_APPEND: out_status_nxt = full ? ppt_pkg::STAT_FULL : ppt_pkg::STAT_OK;
        ppt_pkg::CMD_QUERY:  out_status_nxt = ppt_pkg::STAT_FEW;
        default:             out_status_nxt = ppt_pkg::STAT_OK;
      endcase
    end else if (finish) begin
      out_inside_nxt = edge_inside;
      out_status_nxt = ppt_pkg::STAT_OK;
    end

    if (imm || finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppt_pkg::S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= out_inside_nxt;
    out_status_r <= out_status_nxt;
  end

  ppt_vstore #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (2 * CW)
  ) u_vstore (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[IW-1:0]),
    .wdata ({px_c, py_c}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign bx = rdata[2*CW-1:CW];
  assign by = rdata[CW-1:0];

  ppt_edge_unit #(
    .CW (CW)
  ) u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (query_go),
    .px      (px_c),
    .py      (py_c),
    .ctl     (tag_r),
    .bx      (bx),
    .by      (by),
    .busy    (edge_busy),
    .in_poly (edge_inside)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = out_inside_r;
  assign out_ch.status     = out_status_r;

  `PPT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNTW'(MAX_VERTICES), "vertex count overflow")
  `PPT_ASSERT_SAME(a_walk_min, state_r == ppt_pkg::S_WALK, cnt_r >= MIN_CNT, "walk on short polygon")
  `PPT_ASSERT_SAME(a_idle_quiet, state_r == ppt_pkg::S_IDLE, !edge_busy, "edge pipeline busy")
  `PPT_ASSERT_NEXT(a_append_inc, we, cnt_r == $past(cnt_r) + CNTW'(1), "append lost")

endmodule

### test/ppt_crossing_checker.sv
// Checker for the point-in-polygon block: predicts each result and compares what comes out.
module ppt_crossing_checker #(
  parameter int MAX_VERTICES = 16
) (
  input  logic clk,
  input  logic rst_n,
  ppt_in_if    in_mon,
  ppt_out_if   out_mon,
  output int   fail_count,
  output int   waiting_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  typedef struct packed {
    logic                inside_res;
    logic [STATUS_W-1:0] status;
  } verdict_t;

  logic signed [FIELD_W-1:0] vert_x [MAX_VERTICES];
  logic signed [FIELD_W-1:0] vert_y [MAX_VERTICES];
  int                        vert_count;
  verdict_t                  pending_verdicts [$];

  // Crossing count parity; the slope test is cross-multiplied so no division is needed.
  function automatic logic odd_crossings(input longint px, input longint py);
    longint ax, ay, bx, by, lo, hi, xmax, dy, lhs, rhs;
    logic   parity;
    logic   hit;
    int     i;
    parity = 1'b0;
    ax = vert_x[vert_count-1];
    ay = vert_y[vert_count-1];
    for (i = 0; i < vert_count; i++) begin
      bx = vert_x[i];
      by = vert_y[i];
      if (ay != by) begin
        lo   = (ay < by) ? ay : by;
        hi   = (ay < by) ? by : ay;
        xmax = (ax > bx) ? ax : bx;
        if (py > lo && py <= hi && px <= xmax) begin
          if (ax == bx) begin
            parity = ~parity;
          end else begin
            dy  = by - ay;
            lhs = (px - ax) * dy;
            rhs = (py - ay) * (bx - ax);
            hit = (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
            if (hit) parity = ~parity;
          end
        end
      end
      ax = bx;
      ay = by;
    end
    return parity;
  endfunction

  function automatic verdict_t apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic signed [FIELD_W-1:0] x,
                                             input logic signed [FIELD_W-1:0] y);
    verdict_t v;
    v.inside_res = 1'b0;
    v.status     = STAT_OK;
    case (cmd)
      CMD_CLEAR: begin
        vert_count = 0;
      end
      CMD_APPEND: begin
        if (vert_count < MAX_VERTICES) begin
          vert_x[vert_count] = x;
          vert_y[vert_count] = y;
          vert_count++;
        end else begin
          v.status = STAT_FULL;
        end
      end
      CMD_QUERY: begin
        if (vert_count < MIN_POLY) v.status = STAT_FEW;
        else v.inside_res = odd_crossings(longint'(x), longint'(y));
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      vert_count = 0;
      pending_verdicts.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no transaction waiting: inside=%0d status=%0d",
                     $realtime, out_mon.inside_res, out_mon.status);
        end else begin
          want = pending_verdicts[0];
          pending_verdicts.delete(0);
          if (out_mon.inside_res !== want.inside_res || out_mon.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected inside=%0d status=%0d, got inside=%0d status=%0d",
                       $realtime, want.inside_res, want.status,
                       out_mon.inside_res, out_mon.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_verdicts.push_back(apply_command(in_mon.command, in_mon.coord_x,
                                                 in_mon.coord_y));
    end
    waiting_count = pending_verdicts.size();
  end

endmodule

### test/tb_point_in_polygon_test.sv
// Testbench top for the point-in-polygon block: clock, reset, stimulus and verdict.
module tb_point_in_polygon_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 16;
  localparam int ITEM_GOAL   = 1250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   waiting_count;
  bit   pace_gaps;
  int   sent;
  int   stall_left = 0;
  logic signed [FIELD_W-1:0] poly_x [$];
  logic signed [FIELD_W-1:0] poly_y [$];

  ppt_in_if  in_ch ();
  ppt_out_if out_ch ();

  point_in_polygon_test u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ppt_crossing_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .waiting_count (waiting_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    int r;
    if (!pace_gaps) begin
      stall_left = 0;
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ch.ready = 1'b1;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 2);
        out_ch.ready = 1'b0;
      end else begin
        stall_left = $urandom_range(9, 39);
        out_ch.ready = 1'b0;
      end
    end
  end

  function automatic int idle_gap();
    int r;
    if (!pace_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_coord(input int scale);
    int t;
    case (scale)
      0: t = $urandom_range(0, 16) - 8;
      1: t = $urandom_range(0, 2000) - 1000;
      2: t = $urandom_range(0, 65535);
      default: begin
        case ($urandom_range(0, 6))
          0: t = -32768;
          1: t = -32767;
          2: t = -1;
          3: t = 0;
          4: t = 1;
          5: t = 32766;
          default: t = 32767;
        endcase
      end
    endcase
    return t[FIELD_W-1:0];
  endfunction

  task automatic send(input logic [CMD_W-1:0] cmd, input logic signed [FIELD_W-1:0] x,
                      input logic signed [FIELD_W-1:0] y);
    int gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.command = cmd;
    in_ch.coord_x = x;
    in_ch.coord_y = y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    if (cmd == CMD_CLEAR) begin
      poly_x.delete();
      poly_y.delete();
    end else if (cmd == CMD_APPEND && poly_x.size() < STORE_DEPTH) begin
      poly_x.push_back(x);
      poly_y.push_back(y);
    end
  endtask

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int scale, nv, nq, r, k, q;
    logic signed [FIELD_W-1:0] qx, qy;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_CLEAR;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready  = 1'b0;
    pace_gaps     = 1'b1;
    sent          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(CMD_QUERY, 16'sd0, 16'sd0);
    send(CMD_APPEND, -16'sd32768, -16'sd32768);
    send(CMD_APPEND, 16'sd32767, -16'sd32768);
    send(CMD_QUERY, 16'sd0, 16'sd0);
    send(CMD_APPEND, 16'sd32767, 16'sd32767);
    send(CMD_APPEND, -16'sd32768, 16'sd32767);
    send(CMD_QUERY, 16'sd0, 16'sd0);
    send(CMD_QUERY, 16'sd32767, 16'sd0);
    send(CMD_QUERY, -16'sd32768, -16'sd32768);
    send(CMD_UNUSED, 16'sd32767, -16'sd1);
    for (k = 0; k < 12; k++) send(CMD_APPEND, pick_coord(2), pick_coord(2));
    send(CMD_APPEND, -16'sd1, 16'sd32767);
    send(CMD_CLEAR, -16'sd1, -16'sd1);

    while (sent < ITEM_GOAL) begin
      pace_gaps = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      scale = (r < 4) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
      if ($urandom_range(0, 9) != 0) send(CMD_CLEAR, pick_coord(2), pick_coord(2));
      r = $urandom_range(0, 19);
      if (r < 2) nv = $urandom_range(0, 2);
      else if (r == 2) nv = $urandom_range(15, 18);
      else nv = $urandom_range(3, 8);
      for (k = 0; k < nv; k++) begin
        send(CMD_APPEND, pick_coord(scale), pick_coord(scale));
        if ($urandom_range(0, 29) == 0) send(CMD_UNUSED, pick_coord(2), pick_coord(2));
      end
      nq = $urandom_range(2, 8);
      for (k = 0; k < nq; k++) begin
        qx = pick_coord(scale);
        qy = pick_coord(scale);
        if (poly_x.size() > 0 && $urandom_range(0, 9) < 3) begin
          q = $urandom_range(0, poly_x.size() - 1);
          qx = poly_x[q];
          q = $urandom_range(0, poly_y.size() - 1);
          qy = poly_y[q];
        end
        send(CMD_QUERY, qx, qy);
      end
      if ($urandom_range(0, 7) == 0) send(CMD_UNUSED, pick_coord(2), pick_coord(2));
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    pace_gaps = 1'b0;
    while (waiting_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0 && waiting_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ppt_pkg.sv
rtl/core/ppt_if.sv
rtl/core/ppt_vstore.sv
rtl/core/ppt_edge_unit.sv
rtl/core/point_in_polygon_test.sv
test/ppt_crossing_checker.sv
test/tb_point_in_polygon_test.sv
